/* rtl/ira_pkg.sv */
// Shared types, constants and bit helpers for the id range allocator.
// No dependencies; every other file refers to it by scoped names.
package ira_pkg;

   localparam int ID_SPACE = 1024;
   localparam int ID_W     = 10;               // fixed width of target_id / result_id
   localparam int POS_W    = ID_W + 1;         // range bounds reach ID_SPACE
   localparam int WORD_W   = 16;
   localparam int BIT_W    = 4;
   localparam int ROWS     = ID_SPACE / WORD_W;
   localparam int ROW_W    = $clog2(ROWS);
   localparam int CNT_W    = BIT_W + 1;        // bit index that can also hold WORD_W

   localparam logic [1:0] OP_QUERY = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_TAKE  = 2'd2;
   localparam logic [1:0] OP_CLAIM = 2'd3;

   typedef struct packed {
      logic [1:0]      operation;
      logic [ID_W-1:0] target_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] result_id;
      logic            id_is_free;
      logic            status;
   } rsp_type;

   typedef struct packed {
      logic load;    // capture the request beat
      logic fetch;   // pick the sweep mode and issue the first word read
      logic exec;    // word data is present: evaluate and write back
   } cmd_type;

   typedef struct packed {
      logic last;    // this exec step ends the item
   } stat_type;

   // ones in bits below n, n in 0..WORD_W
   function automatic logic [WORD_W-1:0] low_mask(input logic [CNT_W-1:0] n);
      logic [WORD_W:0] full;
      full = ({{WORD_W{1'b0}}, 1'b1} << n) - {{WORD_W{1'b0}}, 1'b1};
      return full[WORD_W-1:0];
   endfunction

   // index of the lowest zero bit, WORD_W when there is none
   function automatic logic [CNT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
      logic [CNT_W-1:0] r;
      r = CNT_W'(WORD_W);
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) r = CNT_W'(i);
      end
      return r;
   endfunction

endpackage

/* rtl/ira_marks.sv */
// Freed-id bitmap: ROWS words of WORD_W bits, one write and one registered read per cycle.
// Rows carry valid flops cleared by reset; an unwritten row reads as zero. Uses ira_pkg.
module ira_marks (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [ira_pkg::ROW_W-1:0]    wr_addr,
   input  logic [ira_pkg::WORD_W-1:0]   wr_data,
   input  logic [ira_pkg::ROW_W-1:0]    rd_addr,
   output logic [ira_pkg::WORD_W-1:0]   rd_word
);

   logic [ira_pkg::WORD_W-1:0] mem [ira_pkg::ROWS];
   logic [ira_pkg::WORD_W-1:0] rdata_ff;
   logic [ira_pkg::ROWS-1:0]   row_valid_ff;
   logic                       rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rvalid_ff    <= 1'b0;
      end else begin
         if (wr_en) row_valid_ff[wr_addr] <= 1'b1;
         rvalid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_word = rvalid_ff ? rdata_ff : '0;

endmodule

/* rtl/ira_datapath.sv */
// Range registers, request latch, word cursor and per-word evaluation of each operation.
// Holds the bitmap (ira_marks); driven by the controller through ira_pkg::cmd_type.
module ira_datapath (
   input  logic              clock,
   input  logic              reset,
   input  ira_pkg::cmd_type  cmd,
   input  ira_pkg::req_type  req_payload,
   output ira_pkg::stat_type stat,
   output ira_pkg::rsp_type  rsp_payload
);

   localparam logic [1:0] MODE_SINGLE  = 2'd0;
   localparam logic [1:0] MODE_ADVANCE = 2'd1;
   localparam logic [1:0] MODE_TAKE    = 2'd2;
   localparam logic [1:0] MODE_EXTEND  = 2'd3;

   localparam int ID_W  = ira_pkg::ID_W;
   localparam int POS_W = ira_pkg::POS_W;
   localparam int W     = ira_pkg::WORD_W;
   localparam int BW    = ira_pkg::BIT_W;
   localparam int RW    = ira_pkg::ROW_W;
   localparam int CW    = ira_pkg::CNT_W;

   logic [POS_W-1:0] first_ff, first_in, next_ff, next_in, f_ff, f_in;
   logic [1:0]       op_ff, mode_ff, mode_sel;
   logic [ID_W-1:0]  id_ff;
   logic [RW-1:0]    cursor_ff, cursor_in, start_row, rd_addr;
   ira_pkg::rsp_type rsp_ff, rsp_in;

   logic          wr_en;
   logic [W-1:0]  word, wr_data, onehot, clr, ext_mask;
   logic [POS_W-1:0] id_x, first_p1, newf;
   logic [ID_W-1:0]  id_m1;
   logic          empty, bit_set, is_last, at_end;
   logic [CW-1:0] z, tz;
   logic [BW-1:0] lo, hi;

   assign id_x     = {1'b0, id_ff};
   assign first_p1 = first_ff + POS_W'(1);
   assign empty    = (first_ff == next_ff);
   assign id_m1    = id_ff - ID_W'(1);
   assign onehot   = W'(1) << id_ff[BW-1:0];
   assign bit_set  = word[id_ff[BW-1:0]];
   assign at_end   = (cursor_ff == {RW{1'b1}});

   // sweep mode and first row, decided once the request and range are settled
   always_comb begin
      mode_sel  = MODE_SINGLE;
      start_row = id_ff[ID_W-1:BW];
      if (op_ff == ira_pkg::OP_TAKE) begin
         mode_sel  = MODE_TAKE;
         start_row = '0;
      end else if (op_ff == ira_pkg::OP_FREE && !empty && id_x == first_ff) begin
         mode_sel  = MODE_ADVANCE;
         start_row = first_p1[BW+RW-1:BW];
      end else if (op_ff == ira_pkg::OP_CLAIM && !empty && id_x > next_ff) begin
         mode_sel  = MODE_EXTEND;
         start_row = next_ff[BW+RW-1:BW];
      end
   end

   assign rd_addr = cmd.fetch ? start_row : cursor_ff + RW'(1);

   ira_marks u_marks (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (cursor_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_word (word)
   );

   // advance helpers: run of marks from the bit of f upward
   assign z    = ira_pkg::lowest_zero(word | ira_pkg::low_mask({1'b0, f_ff[BW-1:0]}));
   assign clr  = ~ira_pkg::low_mask({1'b0, f_ff[BW-1:0]}) & ira_pkg::low_mask(z);
   assign newf = {1'b0, cursor_ff, {BW{1'b0}}} + POS_W'(z);
   assign tz   = ira_pkg::lowest_zero(~word);

   // extend helpers: mark next .. id-1 within this row
   assign lo       = (cursor_ff == next_ff[BW+RW-1:BW]) ? next_ff[BW-1:0] : '0;
   assign hi       = (cursor_ff == id_m1[ID_W-1:BW]) ? id_m1[BW-1:0] : {BW{1'b1}};
   assign ext_mask = ~ira_pkg::low_mask({1'b0, lo}) & ira_pkg::low_mask({1'b0, hi} + CW'(1));

   always_comb begin
      wr_en     = 1'b0;
      wr_data   = word;
      is_last   = 1'b0;
      first_in  = first_ff;
      next_in   = next_ff;
      f_in      = f_ff;
      cursor_in = cursor_ff;
      rsp_in    = '0;
      if (cmd.fetch) begin
         cursor_in = start_row;
         f_in      = first_p1;
      end else if (cmd.exec) begin
         cursor_in = cursor_ff + RW'(1);
         unique case (mode_ff)
            MODE_SINGLE: begin
               is_last = 1'b1;
               case (op_ff)
                  ira_pkg::OP_QUERY:
                     rsp_in.id_is_free = (id_x < first_ff) || (id_x >= next_ff) || bit_set;
                  ira_pkg::OP_FREE:
                     if (!(id_x < first_ff || id_x >= next_ff || empty || bit_set)) begin
                        wr_en   = 1'b1;
                        wr_data = word | onehot;
                     end
                  ira_pkg::OP_CLAIM:
                     if (id_x <= first_ff) begin
                        rsp_in.status = 1'b1;
                     end else if (id_x >= next_ff) begin
                        if (empty) first_in = id_x;
                        next_in = id_x + POS_W'(1);
                     end else if (!bit_set) begin
                        rsp_in.status = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = word & ~onehot;
                     end
                  default: ;
               endcase
            end
            MODE_ADVANCE: begin
               if (f_ff >= next_ff) begin
                  is_last  = 1'b1;
                  first_in = '0;
                  next_in  = '0;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = word & ~clr;
                  if (z != CW'(W) || at_end) begin
                     is_last = 1'b1;
                     if (newf >= next_ff) begin
                        first_in = '0;
                        next_in  = '0;
                     end else begin
                        first_in = newf;
                     end
                  end else begin
                     f_in = {1'b0, cursor_ff + RW'(1), {BW{1'b0}}};
                  end
               end
            end
            MODE_TAKE: begin
               if (word != '0) begin
                  is_last          = 1'b1;
                  wr_en            = 1'b1;
                  wr_data          = word & (word - W'(1));
                  rsp_in.result_id = {cursor_ff, tz[BW-1:0]};
               end else if (at_end) begin
                  is_last       = 1'b1;
                  rsp_in.status = 1'b1;
               end
            end
            MODE_EXTEND: begin
               wr_en   = 1'b1;
               wr_data = word | ext_mask;
               if (cursor_ff == id_m1[ID_W-1:BW]) begin
                  is_last = 1'b1;
                  next_in = id_x + POS_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         next_ff  <= '0;
      end else begin
         first_ff <= first_in;
         next_ff  <= next_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_payload.operation;
         id_ff <= req_payload.target_id;
      end
      if (cmd.fetch) mode_ff <= mode_sel;
      if (cmd.exec && is_last) rsp_ff <= rsp_in;
      cursor_ff <= cursor_in;
      f_ff      <= f_in;
   end

   assign stat.last   = is_last;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/ira_ctrl.sv */
// Controller: accepts a request beat, sequences fetch and word steps, raises the result strobe.
// Talks to ira_datapath through ira_pkg::cmd_type and ira_pkg::stat_type.
module ira_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ira_pkg::stat_type stat,
   output ira_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_strobe
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC:  if (stat.last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign cmd.load  = (state_ff == ST_IDLE) && start;
   assign cmd.fetch = (state_ff == ST_FETCH);
   assign cmd.exec  = (state_ff == ST_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.exec && stat.last;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

/* rtl/id_range_allocator_top.sv */
// Top level of the id range allocator: controller (ira_ctrl) plus datapath (ira_datapath).
// Uses ira_pkg for payload and command types.
//
//   channel  ports                       handshake
//   request  start, busy, req_payload    beat taken when start && !busy
//   result   rsp_strobe, rsp_payload     one-cycle strobe, receiver cannot stall
//
// An item occupies a fetch step and then a word step for each 16-bit bitmap word it touches;
// the strobe is registered and rises in the cycle after the last word step, when busy is already low again.
// Query, free of an inner id and claim in or next to the range touch a single word.
// Take-lowest, free of the first id and claim past the range sweep successive words.
// The bitmap's separate word read port and word write port limit each step to one word.
// Synchronous reset clears the range and all row valid flags at once; no clearing pass.
module id_range_allocator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ira_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output ira_pkg::rsp_type rsp_payload
);

   ira_pkg::cmd_type  cmd;
   ira_pkg::stat_type stat;

   ira_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   ira_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

/* sim/id_range_allocator_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for id_range_allocator_top: directed range cases, then random traffic.
// A local id-pool predictor supplies expected responses. Depends on ira_pkg and the top.
module id_range_allocator_top_test;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 100;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   ira_pkg::req_type req_payload;
   logic             rsp_strobe;
   ira_pkg::rsp_type rsp_payload;

   // predictor state: live range [span_first, span_next) and freed-id bitmap
   logic [ira_pkg::POS_W-1:0]    span_first;
   logic [ira_pkg::POS_W-1:0]    span_next;
   logic [ira_pkg::ID_SPACE-1:0] freed_map;

   ira_pkg::rsp_type pending_rsp[$];
   int               fail_count;
   int               cycle_count = 0;
   int               idle_percent;

   id_range_allocator_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic ira_pkg::rsp_type apply_to_id_pool(input ira_pkg::req_type rq);
      ira_pkg::rsp_type          rs;
      logic [ira_pkg::POS_W-1:0] pos;
      logic                      hit;
      rs  = '0;
      hit = 1'b0;
      pos = ira_pkg::POS_W'(rq.target_id);
      case (rq.operation)
         ira_pkg::OP_TAKE: begin
            for (int k = 0; k < ira_pkg::ID_SPACE; k++) begin
               if (!hit && freed_map[k]) begin
                  hit          = 1'b1;
                  freed_map[k] = 1'b0;
                  rs.result_id = ira_pkg::ID_W'(k);
               end
            end
            rs.status = !hit;
         end
         ira_pkg::OP_QUERY: begin
            rs.id_is_free = (pos < span_first) || (pos >= span_next) ||
                            freed_map[rq.target_id];
         end
         ira_pkg::OP_FREE: begin
            if (!(pos < span_first || pos >= span_next || freed_map[rq.target_id] ||
                  span_first == span_next)) begin
               if (pos == span_first) begin
                  // range start walks past consecutive freed ids
                  span_first = span_first + 1'b1;
                  while (span_first < span_next &&
                         freed_map[span_first[ira_pkg::ID_W-1:0]]) begin
                     freed_map[span_first[ira_pkg::ID_W-1:0]] = 1'b0;
                     span_first = span_first + 1'b1;
                  end
                  if (span_first >= span_next) begin
                     span_first = '0;
                     span_next  = '0;
                  end
               end else begin
                  freed_map[rq.target_id] = 1'b1;
               end
            end
         end
         ira_pkg::OP_CLAIM: begin
            if (pos <= span_first) begin
               rs.status = 1'b1;
            end else if (pos >= span_next) begin
               if (span_first == span_next) begin
                  span_first = pos;
               end else begin
                  while (span_next < pos) begin
                     freed_map[span_next[ira_pkg::ID_W-1:0]] = 1'b1;
                     span_next = span_next + 1'b1;
                  end
               end
               span_next = pos + 1'b1;
            end else if (!freed_map[rq.target_id]) begin
               rs.status = 1'b1;
            end else begin
               freed_map[rq.target_id] = 1'b0;
            end
         end
         default: rs = '0;
      endcase
      return rs;
   endfunction

   // response checker: every strobe beat pops the oldest expectation
   always @(posedge clock) begin
      ira_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("response beat with nothing expected");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.result_id !== want.result_id) begin
               $error("result_id: expected %0d, got %0d", want.result_id,
                      rsp_payload.result_id);
               fail_count++;
            end
            if (rsp_payload.id_is_free !== want.id_is_free) begin
               $error("id_is_free: expected %0b, got %0b", want.id_is_free,
                      rsp_payload.id_is_free);
               fail_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0b, got %0b", want.status, rsp_payload.status);
               fail_count++;
            end
         end
      end
   end

   task automatic issue_request(input logic [1:0] op,
                                input logic [ira_pkg::ID_W-1:0] id);
      ira_pkg::req_type rq;
      // sender idles cycle by cycle at the phase's rate
      while (idle_percent > 0 && $urandom_range(0, 99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      rq.operation = op;
      rq.target_id = id;
      req_payload <= rq;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(apply_to_id_pool(rq));
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // ids biased toward the range edges so sequences get past the trivial cases
   function automatic logic [ira_pkg::ID_W-1:0] pick_id();
      int r;
      int lo;
      int hi;
      r  = $urandom_range(0, 99);
      lo = int'(span_first);
      hi = int'(span_next);
      if (r < 10)
         return ira_pkg::ID_W'($urandom_range(0, ira_pkg::ID_SPACE - 1));
      if (r < 15)
         return $urandom_range(0, 1) ? ira_pkg::ID_W'(ira_pkg::ID_SPACE - 1) : '0;
      if (hi == lo)
         return ira_pkg::ID_W'($urandom_range(0, 40));
      if (r < 32)
         return ira_pkg::ID_W'(lo);
      if (r < 55) begin
         hi = hi + $urandom_range(0, ($urandom_range(0, 9) == 0) ? 200 : 6);
         return ira_pkg::ID_W'((hi > ira_pkg::ID_SPACE - 1) ? ira_pkg::ID_SPACE - 1 : hi);
      end
      return ira_pkg::ID_W'($urandom_range(lo, span_next - 1));
   endfunction

   task automatic test_directed_cases();
      idle_percent = 0;
      issue_request(ira_pkg::OP_TAKE, 10'd0);       // nothing freed yet
      issue_request(ira_pkg::OP_QUERY, 10'd0);
      issue_request(ira_pkg::OP_QUERY, 10'd1023);
      issue_request(ira_pkg::OP_FREE, 10'd5);       // empty range
      issue_request(ira_pkg::OP_CLAIM, 10'd0);      // at range start while empty
      issue_request(ira_pkg::OP_CLAIM, 10'd5);      // empty range -> [5,6)
      issue_request(ira_pkg::OP_CLAIM, 10'd8);      // skips 6,7
      issue_request(ira_pkg::OP_FREE, 10'd8);
      issue_request(ira_pkg::OP_FREE, 10'd7);       // already marked
      issue_request(ira_pkg::OP_FREE, 10'd2);       // below range
      issue_request(ira_pkg::OP_QUERY, 10'd7);
      issue_request(ira_pkg::OP_QUERY, 10'd5);
      issue_request(ira_pkg::OP_FREE, 10'd5);       // advances past all, range empties
      issue_request(ira_pkg::OP_QUERY, 10'd5);
      issue_request(ira_pkg::OP_CLAIM, 10'd3);
      issue_request(ira_pkg::OP_CLAIM, 10'd40);
      issue_request(ira_pkg::OP_CLAIM, 10'd20);     // marked id inside range
      issue_request(ira_pkg::OP_CLAIM, 10'd20);     // now unmarked
      issue_request(ira_pkg::OP_CLAIM, 10'd2);      // below range
      issue_request(ira_pkg::OP_FREE, 10'd3);       // start advances to 20
      issue_request(ira_pkg::OP_TAKE, 10'd1023);
      issue_request(ira_pkg::OP_CLAIM, 10'd1023);   // long sweep to the top
      issue_request(ira_pkg::OP_QUERY, 10'd1023);
      issue_request(ira_pkg::OP_TAKE, 10'd0);
      issue_request(ira_pkg::OP_FREE, 10'd1023);
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct);
      int          r;
      logic [1:0]  op;
      idle_percent = idle_pct;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 20)      op = ira_pkg::OP_QUERY;
         else if (r < 52) op = ira_pkg::OP_FREE;
         else if (r < 67) op = ira_pkg::OP_TAKE;
         else             op = ira_pkg::OP_CLAIM;
         issue_request(op, pick_id());
      end
   endtask

   task automatic test_drain_pause();
      for (int b = 0; b < 5; b++) begin
         test_random_traffic(20, 0);
         hold_until_drained();
      end
   endtask

   initial begin
      reset        <= 1'b1;
      start        <= 1'b0;
      req_payload  <= '0;
      span_first   = '0;
      span_next    = '0;
      freed_map    = '0;
      fail_count   = 0;
      idle_percent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_traffic(450, 0);
      test_random_traffic(450, 66);
      test_drain_pause();
      test_random_traffic(450, 23);

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d responses never arrived", pending_rsp.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
